@@ rtl/qes_pkg.sv @@
// ---------------------------------------------------------------------------
// qes_pkg - shared types, constants and step functions
// Widths, root kind codes, register indexes, queue entry layout and the
// per-stage arithmetic of the square root and divider pipelines.
// ---------------------------------------------------------------------------
package qes_pkg;

  localparam int COEF_W    = 32;
  localparam int DISC_W    = 66;
  localparam int ROOT_W    = 33;
  localparam int SQ_REM_W  = 36;
  localparam int NUM_W     = 34;
  localparam int DEN_W     = 33;
  localparam int FRAC_W    = 16;
  localparam int DVD_W     = NUM_W + FRAC_W;
  localparam int SQ_STAGES = DISC_W / 2;
  localparam int DV_STAGES = DVD_W;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic CFG_COEF_TOL = 1'b0;
  localparam logic CFG_DISC_TOL = 1'b1;

  localparam logic [15:0] COEF_TOL_RST = 16'd1;
  localparam logic [31:0] DISC_TOL_RST = 32'd42950;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_INF  = 2'd3
  } root_kind_t;

  typedef struct packed {
    root_kind_t                kind;
    logic [DISC_W-1:0]         dmag;
    logic signed [COEF_W-1:0]  coef_b;
    logic                      a_neg;
    logic [NUM_W-1:0]          num;
    logic [DEN_W-1:0]          den;
    logic                      neg;
  } fe_entry_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_state_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DVD_W-1:0] z;
  } dv_state_t;

  typedef struct packed {
    logic              sat;
    logic [COEF_W-1:0] val;
  } fix_t;

  // one bit pair of the integer square root
  function automatic sq_state_t sqrt_step(sq_state_t s, logic [1:0] pair);
    logic [SQ_REM_W-1:0] remx;
    logic [SQ_REM_W-1:0] trial;
    sq_state_t           o;
    remx  = {s.rem[SQ_REM_W-3:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (remx >= trial) begin
      o.rem  = remx - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = remx;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of the restoring division
  function automatic dv_state_t div_step(dv_state_t s, logic [DEN_W-1:0] den);
    logic [DEN_W:0] remx;
    logic           ge;
    dv_state_t      o;
    remx  = {s.rem, s.z[DVD_W-1]};
    ge    = (remx >= {1'b0, den});
    o.rem = ge ? DEN_W'(remx - {1'b0, den}) : remx[DEN_W-1:0];
    o.z   = {s.z[DVD_W-2:0], ge};
    return o;
  endfunction

  // apply sign and clamp to Q16.16
  function automatic fix_t fix_root(logic neg, logic [DVD_W-1:0] q);
    fix_t o;
    o.sat = 1'b0;
    o.val = '0;
    if (q != '0) begin
      if (neg) begin
        if (q > DVD_W'(33'h0_8000_0000)) begin
          o.sat = 1'b1;
          o.val = 32'h8000_0000;
        end else begin
          o.val = COEF_W'(~q[COEF_W-1:0] + 32'd1);
        end
      end else begin
        if (q > DVD_W'(32'h7FFF_FFFF)) begin
          o.sat = 1'b1;
          o.val = 32'h7FFF_FFFF;
        end else begin
          o.val = q[COEF_W-1:0];
        end
      end
    end
    return o;
  endfunction

endpackage

@@ rtl/qes_in_if.sv @@
// ---------------------------------------------------------------------------
// qes_in_if - coefficient channel
// Valid/ready channel carrying the three Q16.16 coefficients of one item.
// ---------------------------------------------------------------------------
interface qes_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

@@ rtl/qes_out_if.sv @@
// ---------------------------------------------------------------------------
// qes_out_if - root channel
// Valid/ready channel carrying the root kind, both roots and the clamp flag.
// ---------------------------------------------------------------------------
interface qes_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  root_kind;
  logic signed [31:0] first_root;
  logic signed [31:0] second_root;
  logic        saturated;

  modport source (output valid, output root_kind, output first_root,
                  output second_root, output saturated, input ready);
  modport sink   (input valid, input root_kind, input first_root,
                  input second_root, input saturated, output ready);
endinterface

@@ rtl/quadratic_equation_solver.sv @@
// ---------------------------------------------------------------------------
// quadratic_equation_solver - real roots of a*x^2 + b*x + c = 0
// Coefficients in, root kind and Q16.16 roots out, one item per cycle.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  carries coef_a, coef_b, coef_c (signed Q16.16) with valid/ready;
//          an item is taken on a clock edge with valid and ready both high.
//   out_ch carries root_kind, first_root, second_root and saturated.
//   cfg_we/cfg_index/cfg_data write coef_tolerance (index 0) and
//   disc_tolerance (index 1); write only while no item is in flight.
// Throughput: one item per cycle, sustained while out_ch is ready.
// Path: from the accepting edge to the result register with an empty queue,
//   an item passes the second front stage, the queue, 33 square root
//   stages, one numerator stage, 50 divider stages and the output register.
//   The divider, one quotient bit per stage, is the longest part of it.
// Reset: rst_n is synchronous and active low; it empties the pipelines and
//   the queue and loads the tolerance registers with their reset values.
// Stall: when out_ch holds back, the result stays put and the back end
//   freezes; the front keeps taking items until the queue fills, then
//   drops in_ch.ready.
// ---------------------------------------------------------------------------
module quadratic_equation_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  qes_in_if.sink      in_ch,
  qes_out_if.source   out_ch
);

  logic [15:0] coef_tol_r;
  logic [31:0] disc_tol_r;

  // tolerance registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_tol_r <= qes_pkg::COEF_TOL_RST;
      disc_tol_r <= qes_pkg::DISC_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qes_pkg::CFG_COEF_TOL: coef_tol_r <= cfg_data[15:0];
        qes_pkg::CFG_DISC_TOL: disc_tol_r <= cfg_data;
        default:               coef_tol_r <= coef_tol_r;
      endcase
    end
  end

  logic               q_push, q_pop, q_full, q_empty;
  qes_pkg::fe_entry_t q_in, q_head;
  logic [1:0]         kind;

  // classify each item and hand it to the queue
  qes_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef_tol (coef_tol_r),
    .disc_tol (disc_tol_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_a     (in_ch.coef_a),
    .in_b     (in_ch.coef_b),
    .in_c     (in_ch.coef_c),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // decouple front and back so that each may stall alone
  qes_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  // square root, division and clamping
  qes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (kind),
    .out_first  (out_ch.first_root),
    .out_second (out_ch.second_root),
    .out_sat    (out_ch.saturated)
  );

  assign out_ch.root_kind = kind;

endmodule

@@ rtl/qes_front.sv @@
// ---------------------------------------------------------------------------
// qes_front - coefficient classification
// Two stages: magnitudes, zero tests and products, then the discriminant
// and the choice of case, emitted as a queue entry.
// ---------------------------------------------------------------------------
module qes_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [15:0]               coef_tol,
  input  logic [31:0]               disc_tol,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        in_a,
  input  logic signed [31:0]        in_b,
  input  logic signed [31:0]        in_c,
  input  logic                      q_full,
  output logic                      q_push,
  output qes_pkg::fe_entry_t        q_entry
);

  logic               f1_v_r;
  logic signed [31:0] f1_a_r, f1_b_r, f1_c_r;

  logic               f2_v_r;
  logic               f2_a_neg_r, f2_b_neg_r, f2_c_neg_r;
  logic               f2_az_r, f2_bz_r, f2_cz_r;
  logic [31:0]        f2_am_r, f2_bm_r, f2_cm_r;
  logic signed [31:0] f2_b_r;
  logic [63:0]        f2_b2_r, f2_p_r;

  logic        adv;
  logic [31:0] am, bm, cm;
  logic        az, bz, cz;

  assign adv      = !f2_v_r || !q_full;
  assign in_ready = adv;
  assign q_push   = f2_v_r && !q_full;

  assign am = f1_a_r[31] ? 32'(~f1_a_r + 32'sd1) : f1_a_r;
  assign bm = f1_b_r[31] ? 32'(~f1_b_r + 32'sd1) : f1_b_r;
  assign cm = f1_c_r[31] ? 32'(~f1_c_r + 32'sd1) : f1_c_r;
  assign az = (am == '0) || (am < {16'd0, coef_tol});
  assign bz = (bm == '0) || (bm < {16'd0, coef_tol});
  assign cz = (cm == '0) || (cm < {16'd0, coef_tol});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_a_r     <= in_a;
      f1_b_r     <= in_b;
      f1_c_r     <= in_c;
      f2_a_neg_r <= f1_a_r[31];
      f2_b_neg_r <= f1_b_r[31];
      f2_c_neg_r <= f1_c_r[31];
      f2_az_r    <= az;
      f2_bz_r    <= bz;
      f2_cz_r    <= cz;
      f2_am_r    <= am;
      f2_bm_r    <= bm;
      f2_cm_r    <= cm;
      f2_b_r     <= f1_b_r;
      f2_b2_r    <= bm * bm;
      f2_p_r     <= am * cm;
    end
  end

  logic [65:0] p4, b2x, d;
  logic        ac_neg, d_neg, near, b_pos, c_pos;

  always_comb begin
    p4     = {f2_p_r, 2'b00};
    b2x    = {2'b00, f2_b2_r};
    ac_neg = (f2_a_neg_r != f2_c_neg_r) && (f2_p_r != '0);
    b_pos  = !f2_b_neg_r && (f2_bm_r != '0);
    c_pos  = !f2_c_neg_r && (f2_cm_r != '0);
    if (ac_neg) begin
      d     = b2x + p4;
      d_neg = 1'b0;
    end else if (p4 > b2x) begin
      d     = p4 - b2x;
      d_neg = 1'b1;
    end else begin
      d     = b2x - p4;
      d_neg = 1'b0;
    end
    near = (d < {34'd0, disc_tol});

    q_entry.kind   = qes_pkg::KIND_NONE;
    q_entry.dmag   = '0;
    q_entry.coef_b = f2_b_r;
    q_entry.a_neg  = f2_a_neg_r;
    q_entry.num    = '0;
    q_entry.den    = 33'd1;
    q_entry.neg    = 1'b0;
    if (f2_az_r) begin
      if (f2_bz_r) begin
        q_entry.kind = f2_cz_r ? qes_pkg::KIND_INF : qes_pkg::KIND_NONE;
      end else begin
        q_entry.kind = qes_pkg::KIND_ONE;
        q_entry.neg  = c_pos != f2_b_neg_r;
        q_entry.num  = {2'b00, f2_cm_r};
        q_entry.den  = {1'b0, f2_bm_r};
      end
    end else begin
      q_entry.den = {f2_am_r, 1'b0};
      if (near) begin
        q_entry.kind = qes_pkg::KIND_ONE;
        q_entry.neg  = b_pos != f2_a_neg_r;
        q_entry.num  = {2'b00, f2_bm_r};
      end else if (!d_neg) begin
        q_entry.kind = qes_pkg::KIND_TWO;
        q_entry.dmag = d;
      end
    end
  end

endmodule

@@ rtl/qes_queue.sv @@
// ---------------------------------------------------------------------------
// qes_queue - entry queue between front and back
// Small FIFO of classified entries; head is presented combinationally.
// ---------------------------------------------------------------------------
module qes_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qes_pkg::fe_entry_t  push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output qes_pkg::fe_entry_t  head
);

  qes_pkg::fe_entry_t              mem [qes_pkg::Q_DEPTH];
  logic [qes_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [qes_pkg::Q_PTR_W:0]       count_r;

  assign full  = (count_r == (qes_pkg::Q_PTR_W+1)'(qes_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue pop while empty");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

@@ rtl/qes_back.sv @@
// ---------------------------------------------------------------------------
// qes_back - root evaluation
// Pipelined integer square root, numerator stage, two pipelined dividers
// and the output register with clamping.
// ---------------------------------------------------------------------------
module qes_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  qes_pkg::fe_entry_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic signed [31:0]  out_first,
  output logic signed [31:0]  out_second,
  output logic                out_sat
);

  localparam int SQ = qes_pkg::SQ_STAGES;
  localparam int DV = qes_pkg::DV_STAGES;

  logic adv;

  // square root stages
  logic                 sq_v_r [SQ];
  qes_pkg::fe_entry_t   sq_e_r [SQ];
  qes_pkg::sq_state_t   sq_s_r [SQ];
  qes_pkg::sq_state_t   sq_nxt [SQ];

  // numerator stage
  logic                       pr_v_r;
  qes_pkg::root_kind_t        pr_kind_r;
  logic [qes_pkg::NUM_W-1:0]  pr_num1_r, pr_num2_r;
  logic                       pr_neg1_r, pr_neg2_r;
  logic [qes_pkg::DEN_W-1:0]  pr_den_r;

  // divider stages
  logic                       dv_v_r    [DV];
  qes_pkg::root_kind_t        dv_kind_r [DV];
  logic                       dv_neg1_r [DV];
  logic                       dv_neg2_r [DV];
  logic [qes_pkg::DEN_W-1:0]  dv_den_r  [DV];
  qes_pkg::dv_state_t         dv1_r     [DV];
  qes_pkg::dv_state_t         dv2_r     [DV];
  qes_pkg::dv_state_t         dv1_nxt   [DV];
  qes_pkg::dv_state_t         dv2_nxt   [DV];

  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic signed [31:0]  out_first_r, out_second_r;
  logic                out_sat_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    sq_nxt[0] = qes_pkg::sqrt_step('0, q_head.dmag[2*(SQ-1) +: 2]);
    for (int k = 1; k < SQ; k++) begin
      sq_nxt[k] = qes_pkg::sqrt_step(sq_s_r[k-1], sq_e_r[k-1].dmag[2*(SQ-1-k) +: 2]);
    end
  end

  // numerators from -b and the root
  logic [qes_pkg::ROOT_W-1:0] s;
  logic signed [34:0]         bx, n1, n2;
  logic [qes_pkg::NUM_W-1:0]  n1m, n2m;
  qes_pkg::fe_entry_t         se;

  always_comb begin
    se  = sq_e_r[SQ-1];
    s   = sq_s_r[SQ-1].root;
    bx  = 35'(se.coef_b);
    n1  = -bx - $signed({2'b00, s});
    n2  = -bx + $signed({2'b00, s});
    n1m = n1[34] ? qes_pkg::NUM_W'(-n1) : n1[qes_pkg::NUM_W-1:0];
    n2m = n2[34] ? qes_pkg::NUM_W'(-n2) : n2[qes_pkg::NUM_W-1:0];
  end

  always_comb begin
    dv1_nxt[0] = qes_pkg::div_step('{rem: '0, z: {pr_num1_r, 16'd0}}, pr_den_r);
    dv2_nxt[0] = qes_pkg::div_step('{rem: '0, z: {pr_num2_r, 16'd0}}, pr_den_r);
    for (int k = 1; k < DV; k++) begin
      dv1_nxt[k] = qes_pkg::div_step(dv1_r[k-1], dv_den_r[k-1]);
      dv2_nxt[k] = qes_pkg::div_step(dv2_r[k-1], dv_den_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k < DV; k++) dv_v_r[k] <= 1'b0;
      pr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= !q_empty;
      for (int k = 1; k < SQ; k++) sq_v_r[k] <= sq_v_r[k-1];
      pr_v_r    <= sq_v_r[SQ-1];
      dv_v_r[0] <= pr_v_r;
      for (int k = 1; k < DV; k++) dv_v_r[k] <= dv_v_r[k-1];
      out_valid_r <= dv_v_r[DV-1];
    end
  end

  qes_pkg::fix_t f1, f2;
  logic          use1, use2;

  always_comb begin
    f1   = qes_pkg::fix_root(dv_neg1_r[DV-1], dv1_r[DV-1].z);
    f2   = qes_pkg::fix_root(dv_neg2_r[DV-1], dv2_r[DV-1].z);
    use1 = (dv_kind_r[DV-1] == qes_pkg::KIND_ONE) || (dv_kind_r[DV-1] == qes_pkg::KIND_TWO);
    use2 = (dv_kind_r[DV-1] == qes_pkg::KIND_TWO);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_e_r[0] <= q_head;
      sq_s_r[0] <= sq_nxt[0];
      for (int k = 1; k < SQ; k++) begin
        sq_e_r[k] <= sq_e_r[k-1];
        sq_s_r[k] <= sq_nxt[k];
      end

      pr_kind_r <= se.kind;
      pr_den_r  <= se.den;
      if (se.kind == qes_pkg::KIND_TWO) begin
        pr_num1_r <= n1m;
        pr_neg1_r <= n1[34] != se.a_neg;
        pr_num2_r <= n2m;
        pr_neg2_r <= n2[34] != se.a_neg;
      end else begin
        pr_num1_r <= se.num;
        pr_neg1_r <= se.neg;
        pr_num2_r <= '0;
        pr_neg2_r <= 1'b0;
      end

      dv_kind_r[0] <= pr_kind_r;
      dv_neg1_r[0] <= pr_neg1_r;
      dv_neg2_r[0] <= pr_neg2_r;
      dv_den_r[0]  <= pr_den_r;
      dv1_r[0]     <= dv1_nxt[0];
      dv2_r[0]     <= dv2_nxt[0];
      for (int k = 1; k < DV; k++) begin
        dv_kind_r[k] <= dv_kind_r[k-1];
        dv_neg1_r[k] <= dv_neg1_r[k-1];
        dv_neg2_r[k] <= dv_neg2_r[k-1];
        dv_den_r[k]  <= dv_den_r[k-1];
        dv1_r[k]     <= dv1_nxt[k];
        dv2_r[k]     <= dv2_nxt[k];
      end

      out_kind_r   <= dv_kind_r[DV-1];
      out_first_r  <= use1 ? f1.val : '0;
      out_second_r <= use2 ? f2.val : '0;
      out_sat_r    <= (use1 && f1.sat) || (use2 && f2.sat);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;
  assign out_sat    = out_sat_r;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_first_r)))
    else $error("result changed while stalled");
  a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !q_pop)
    else $error("queue drained while back end stalled");
  a_zero_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != qes_pkg::KIND_TWO) |-> (out_second_r == '0))
    else $error("second root set without two roots");

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb - testbench for quadratic_equation_solver
// Drives coefficient items with bursty timing while the result side stalls
// on its own pattern, predicts every result in a local model of the
// quadratic formula and checks each item field by field, in order.
// ---------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } coefs_t;

  typedef struct {
    qes_pkg::root_kind_t kind;
    logic signed [31:0]  r1;
    logic signed [31:0]  r2;
    logic                sat;
  } roots_t;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = qes_pkg::CFG_COEF_TOL;
  logic [31:0] cfg_data = '0;

  qes_in_if  in_ch ();
  qes_out_if out_ch ();

  quadratic_equation_solver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #5 clk = ~clk;

  // local copy of the tolerance registers
  logic [15:0] coef_tol = qes_pkg::COEF_TOL_RST;
  logic [31:0] disc_tol = qes_pkg::DISC_TOL_RST;

  coefs_t pending_eqs[$];
  roots_t expected_roots[$];
  int     n_errors = 0;
  int     ready_pct = 100;

  // ---- prediction ---------------------------------------------------------
  function automatic logic [31:0] mag32(logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic counts_as_zero(logic signed [31:0] x);
    logic [31:0] m;
    m = mag32(x);
    return (m == 0) || (m < {16'd0, coef_tol});
  endfunction

  // Q16.16 quotient, truncated towards zero, clamped on overflow
  function automatic logic signed [31:0] q16_div(logic neg, logic [39:0] num,
                                                 logic [32:0] den, inout logic sat);
    logic [63:0] q;
    q = ({24'd0, num} << 16) / {31'd0, den};
    if (q == 0) return 32'sd0;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'sh8000_0000;
      end
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic roots_t solve_quadratic(coefs_t e);
    roots_t             r;
    logic [31:0]        am, bm, cm;
    logic [69:0]        bsq, p4, dm;
    logic signed [69:0] disc;
    logic [35:0]        s;
    logic signed [39:0] n1, n2;
    logic [32:0]        den;
    logic               sat;
    r.kind = qes_pkg::KIND_NONE;
    r.r1   = '0;
    r.r2   = '0;
    sat    = 1'b0;
    am = mag32(e.a);
    bm = mag32(e.b);
    cm = mag32(e.c);
    if (counts_as_zero(e.a)) begin
      if (counts_as_zero(e.b)) begin
        r.kind = counts_as_zero(e.c) ? qes_pkg::KIND_INF : qes_pkg::KIND_NONE;
      end else begin
        r.kind = qes_pkg::KIND_ONE;
        r.r1 = q16_div((e.c > 0) != e.b[31], {8'd0, cm}, {1'b0, bm}, sat);
      end
    end else begin
      bsq  = 70'(bm) * 70'(bm);
      p4   = (70'(am) * 70'(cm)) << 2;
      disc = (e.a[31] != e.c[31]) ? signed'(bsq + p4) : signed'(bsq - p4);
      dm   = disc[69] ? -disc : disc;
      den  = {am, 1'b0};
      if (dm < 70'(disc_tol)) begin
        r.kind = qes_pkg::KIND_ONE;
        r.r1 = q16_div((e.b > 0) != e.a[31], {8'd0, bm}, den, sat);
      end else if (!disc[69]) begin
        // floor of the integer square root, bit by bit from the top
        s = '0;
        for (int i = 34; i >= 0; i--) begin
          if (72'(s | (36'd1 << i)) * 72'(s | (36'd1 << i)) <= 72'(dm))
            s = s | (36'd1 << i);
        end
        n1 = -40'(e.b) - 40'(s);
        n2 = -40'(e.b) + 40'(s);
        r.kind = qes_pkg::KIND_TWO;
        r.r1 = q16_div(n1[39] != e.a[31], n1[39] ? -n1 : n1, den, sat);
        r.r2 = q16_div(n2[39] != e.a[31], n2[39] ? -n2 : n2, den, sat);
      end
    end
    r.sat = sat;
    return r;
  endfunction

  // ---- driver: bursts of items separated by random gaps -------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.coef_a <= '0;
      in_ch.coef_b <= '0;
      in_ch.coef_c <= '0;
    end else begin
      // record the accepted item and predict its result
      if (in_ch.valid && in_ch.ready) begin
        expected_roots.push_back(solve_quadratic(pending_eqs.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_eqs.size() > 0) begin
          in_ch.valid  <= 1'b1;
          in_ch.coef_a <= pending_eqs[0].a;
          in_ch.coef_b <= pending_eqs[0].b;
          in_ch.coef_c <= pending_eqs[0].c;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor: stall pattern and in-order check ---------------------------
  int stall_phase = 0;

  always @(posedge clk) begin
    roots_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected item: kind %0d first %0h second %0h", out_ch.root_kind,
                 out_ch.first_root, out_ch.second_root);
          n_errors++;
        end else begin
          exp_r = expected_roots.pop_front();
          if (out_ch.root_kind !== exp_r.kind) begin
            $error("root_kind: expected %0d, got %0d", exp_r.kind, out_ch.root_kind);
            n_errors++;
          end
          if (out_ch.first_root !== exp_r.r1) begin
            $error("first_root: expected %0h, got %0h", exp_r.r1, out_ch.first_root);
            n_errors++;
          end
          if (out_ch.second_root !== exp_r.r2) begin
            $error("second_root: expected %0h, got %0h", exp_r.r2, out_ch.second_root);
            n_errors++;
          end
          if (out_ch.saturated !== exp_r.sat) begin
            $error("saturated: expected %0d, got %0d", exp_r.sat, out_ch.saturated);
            n_errors++;
          end
        end
      end
      // change the stall density each time the phase counter wraps
      stall_phase++;
      if (stall_phase == 300) begin
        stall_phase = 0;
        case ($urandom_range(0, 3))
          0: begin ready_pct = 100; end
          1: begin ready_pct = 25; end
          2: begin ready_pct = 60; end
          default: begin ready_pct = 90; end
        endcase
      end
      out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // ---- watchdog: cycles with work outstanding but no handshake ------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_eqs.size() == 0 && expected_roots.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- stimulus ------------------------------------------------------------
  task automatic push_eq(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    coefs_t e;
    e.a = a;
    e.b = b;
    e.c = c;
    pending_eqs.push_back(e);
  endtask

  // hold until every result is in, then let the pipeline run dry
  task automatic drain();
    while (pending_eqs.size() != 0 || expected_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == qes_pkg::CFG_COEF_TOL) coef_tol = val[15:0];
    else disc_tol = val;
  endtask

  // random equation, weighted towards the interesting shapes
  task automatic push_random();
    int          r1, r2, k;
    logic [31:0] t;
    t = {16'd0, coef_tol};
    case ($urandom_range(0, 9))
      0, 1: begin
        push_eq($urandom, $urandom, $urandom);
      end
      2, 3: begin
        // integer roots: a = k, b = -k(r1+r2), c = k*r1*r2
        k  = $urandom_range(1, 4) * (($urandom_range(0, 1) != 0) ? 1 : -1);
        r1 = $urandom_range(0, 40) - 20;
        r2 = ($urandom_range(0, 3) == 0) ? r1 : $urandom_range(0, 40) - 20;
        push_eq(k << 16, (-k * (r1 + r2)) << 16, (k * r1 * r2) << 16);
      end
      4, 5: begin
        push_eq($urandom_range(0, 'h7FFFF) - 'h40000, $urandom_range(0, 'h7FFFF) - 'h40000,
                $urandom_range(0, 'h7FFFF) - 'h40000);
      end
      6: begin
        // linear or degenerate, with coefficients around the tolerance
        push_eq($urandom_range(0, 1) ? 32'd0 : t - $urandom_range(0, 1),
                $urandom_range(0, 1) ? $urandom : t + $urandom_range(0, 1) - 1,
                $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(0, 3) - 1);
      end
      7: begin
        // tiny a against large b and c drives roots out of range
        push_eq($urandom_range(1, 300) * (($urandom_range(0, 1) != 0) ? 1 : -1),
                $urandom, $urandom);
      end
      default: begin
        push_eq($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF, $urandom,
                $urandom_range(0, 1) ? 32'h8000_0000 : $urandom);
      end
    endcase
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: degenerate cases, extremes, tangent, complex and clamped roots
    push_eq(0, 0, 0);                                  // infinitely many
    push_eq(0, 0, 32'h0001_0000);                      // none
    push_eq(0, 32'h0002_0000, 32'h0004_0000);          // linear, root -2
    push_eq(0, 32'h0001_0000, 32'd1);                  // linear, small c
    push_eq(0, 32'hFFFF_0000, 32'hFFFF_FFFF);          // linear, small negative c
    push_eq(0, 32'd1, 32'h7FFF_FFFF);                  // linear, clamped low
    push_eq(0, 32'd1, 32'h8000_0000);                  // linear, clamped high
    push_eq(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000); // tangent at 1
    push_eq(32'h0001_0000, 0, 32'h0001_0000);          // complex pair
    push_eq(32'h0001_0000, 0, 32'hFFFF_0000);          // +-1
    push_eq(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000); // 1 and 2
    push_eq(32'hFFFF_0000, 32'h0003_0000, 32'hFFFE_0000); // negative a
    push_eq(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_eq(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_eq(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_eq(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    push_eq(32'd1, 32'h8000_0000, 0);                  // clamped two roots
    push_eq(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_eq(32'hFFFF_FFFF, 0, 32'h8000_0000);
    push_eq(32'd2, 32'd3, 0);
    push_eq(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    drain();

    // phases of tolerance settings; the sender pauses once in each
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(qes_pkg::CFG_COEF_TOL, 0);
          write_reg(qes_pkg::CFG_DISC_TOL, 0);
        end
        1: begin
          write_reg(qes_pkg::CFG_COEF_TOL, 16'hFFFF);
          write_reg(qes_pkg::CFG_DISC_TOL, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(qes_pkg::CFG_COEF_TOL, $urandom_range(0, 65535));
          write_reg(qes_pkg::CFG_DISC_TOL, $urandom);
        end
        3: begin
          write_reg(qes_pkg::CFG_COEF_TOL, $urandom_range(0, 16));
          write_reg(qes_pkg::CFG_DISC_TOL, 1);
        end
        default: begin
          write_reg(qes_pkg::CFG_COEF_TOL, qes_pkg::COEF_TOL_RST);
          write_reg(qes_pkg::CFG_DISC_TOL, qes_pkg::DISC_TOL_RST);
        end
      endcase
      n = 166;
      for (int i = 0; i < n / 2; i++) push_random();
      drain();
      for (int i = n / 2; i < n; i++) push_random();
      drain();
    end

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
